/* rtl/dmwbc_pkg.sv */
// Shared constants for the direct-mapped write-back cache.
// Used by the channel interfaces and the cache top level; no dependencies.
package dmwbc_pkg;

    localparam int ADDR_W = 11;
    localparam int DATA_W = 8;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [DATA_W-1:0] byte_t;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

endpackage

/* rtl/dmwbc_if.sv */
// Request and response channels of the cache, valid/ready handshake.
// Depends on dmwbc_pkg for the payload types.
interface dmwbc_req_if;
    logic                valid;
    logic                ready;
    logic                operation;
    dmwbc_pkg::addr_t    address;
    dmwbc_pkg::byte_t    write_data;

    modport source (output valid, output operation, output address, output write_data,
                    input ready);
    modport sink   (input valid, input operation, input address, input write_data,
                    output ready);
endinterface

interface dmwbc_rsp_if;
    logic                valid;
    logic                ready;
    dmwbc_pkg::byte_t    read_data;
    logic                hit;

    modport source (output valid, output read_data, output hit, input ready);
    modport sink   (input valid, input read_data, input hit, output ready);
endinterface

/* rtl/direct_mapped_writeback_cache_unit.sv */
// Direct-mapped, write-back, write-allocate byte cache with its backing memory.
// Depends on dmwbc_pkg and the channel interfaces in dmwbc_if.sv.
//
// Usage: each item on req is one byte access (operation 0 read, 1 write) at
// address; rsp returns one item per request with read_data (zero on writes)
// and hit, in request order. NUM_SLOTS, BLOCK_BYTES and 2**TAG_BITS are
// powers of two; the address is taken modulo the backing memory size.
// Line data and the backing memory are single-port-per-side synchronous RAMs
// with registered read data; tags, valid and dirty bits are flops.
// On a miss the block fills the line from backing memory, first writing back
// a dirty victim. One item is worked at a time; a hit passes through lookup,
// line RAM access and result load. The fill and write-back copy one byte per
// cycle through the RAM ports.
// Reset: the block clears the backing memory one byte per cycle, holding
// req.ready low; all slots start invalid and clean.
// Stall: a result waits in the output register while rsp.ready is low; the
// next request is still accepted and worked up to its own result load.
module direct_mapped_writeback_cache_unit #(
    parameter int NUM_SLOTS   = 16,
    parameter int BLOCK_BYTES = 16,
    parameter int TAG_BITS    = 3
) (
    input  logic         clk,
    input  logic         rst_n,
    dmwbc_req_if.sink    req,
    dmwbc_rsp_if.source  rsp
);

    localparam int OFF_W      = $clog2(BLOCK_BYTES);
    localparam int IDX_W      = $clog2(NUM_SLOTS);
    localparam int LINE_W     = IDX_W + OFF_W;
    localparam int MEM_ADDR_W = TAG_BITS + LINE_W;
    localparam int LINE_BYTES = NUM_SLOTS * BLOCK_BYTES;
    localparam int MEM_BYTES  = LINE_BYTES * (2 ** TAG_BITS);
    localparam int DATA_W     = dmwbc_pkg::DATA_W;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_LOOKUP = 3'd2;
    localparam logic [2:0] ST_WB     = 3'd3;
    localparam logic [2:0] ST_FILL   = 3'd4;
    localparam logic [2:0] ST_ACCESS = 3'd5;
    localparam logic [2:0] ST_RESP   = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic                  op_reg;
    logic [MEM_ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0]     wdata_reg;
    logic                  hit_reg, hit_next;
    logic [OFF_W:0]        cnt_reg, cnt_next;
    logic                  pend_reg, pend_next;
    logic [OFF_W-1:0]      pend_off_reg;
    logic [MEM_ADDR_W-1:0] clr_addr_reg;

    logic [TAG_BITS-1:0]   tag_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]  valid_reg;
    logic [NUM_SLOTS-1:0]  dirty_reg;

    logic                  rsp_valid_reg;
    logic [DATA_W-1:0]     rsp_data_reg;
    logic                  rsp_hit_reg;

    logic [DATA_W-1:0]     line_mem [LINE_BYTES];
    logic [DATA_W-1:0]     back_mem [MEM_BYTES];
    logic [DATA_W-1:0]     line_q;
    logic [DATA_W-1:0]     back_q;

    logic                  line_we, line_re;
    logic [LINE_W-1:0]     line_waddr, line_raddr;
    logic [DATA_W-1:0]     line_wdata;
    logic                  back_we, back_re;
    logic [MEM_ADDR_W-1:0] back_waddr, back_raddr;
    logic [DATA_W-1:0]     back_wdata;

    logic                  meta_fill;
    logic                  meta_dirty;
    logic                  rsp_load;

    logic [TAG_BITS-1:0]   a_tag;
    logic [IDX_W-1:0]      a_slot;
    logic [OFF_W-1:0]      a_off;
    logic [OFF_W-1:0]      cnt_off;
    logic                  cnt_done;

    assign a_tag    = addr_reg[MEM_ADDR_W-1 -: TAG_BITS];
    assign a_slot   = addr_reg[OFF_W +: IDX_W];
    assign a_off    = addr_reg[OFF_W-1:0];
    assign cnt_off  = cnt_reg[OFF_W-1:0];
    assign cnt_done = cnt_reg[OFF_W];

    assign req.ready     = (state_reg == ST_IDLE);
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.read_data = rsp_data_reg;
    assign rsp.hit       = rsp_hit_reg;

    always_comb
    begin
        state_next = state_reg;
        hit_next   = hit_reg;
        cnt_next   = cnt_reg;
        pend_next  = ((state_reg == ST_WB) || (state_reg == ST_FILL)) && !cnt_done;
        meta_fill  = 1'b0;
        meta_dirty = 1'b0;
        rsp_load   = 1'b0;

        line_we    = 1'b0;
        line_waddr = {a_slot, pend_off_reg};
        line_wdata = back_q;
        line_re    = 1'b0;
        line_raddr = {a_slot, a_off};
        back_we    = 1'b0;
        back_waddr = {tag_reg[a_slot], a_slot, pend_off_reg};
        back_wdata = line_q;
        back_re    = 1'b0;
        back_raddr = {a_tag, a_slot, cnt_off};

        unique case (state_reg)
            ST_CLEAR:
            begin
                back_we    = 1'b1;
                back_waddr = clr_addr_reg;
                back_wdata = '0;
                if (&clr_addr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                hit_next = valid_reg[a_slot] && (tag_reg[a_slot] == a_tag);
                cnt_next = '0;
                priority if (hit_next)
                begin
                    state_next = ST_ACCESS;
                end
                else if (valid_reg[a_slot] && dirty_reg[a_slot])
                begin
                    state_next = ST_WB;
                end
                else
                begin
                    state_next = ST_FILL;
                end
            end
            ST_WB:
            begin
                // read victim byte now, write it to backing memory next cycle
                line_re    = !cnt_done;
                line_raddr = {a_slot, cnt_off};
                back_we    = pend_reg;
                cnt_next   = cnt_reg + (OFF_W+1)'(1);
                if (cnt_done)
                begin
                    cnt_next   = '0;
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                back_re  = !cnt_done;
                line_we  = pend_reg;
                cnt_next = cnt_reg + (OFF_W+1)'(1);
                if (cnt_done)
                begin
                    meta_fill  = 1'b1;
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                if (op_reg == dmwbc_pkg::OP_WRITE)
                begin
                    line_we    = 1'b1;
                    line_waddr = {a_slot, a_off};
                    line_wdata = wdata_reg;
                    meta_dirty = 1'b1;
                end
                else
                begin
                    line_re = 1'b1;
                end
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + MEM_ADDR_W'(1);
            end
            if (meta_fill)
            begin
                valid_reg[a_slot] <= 1'b1;
                dirty_reg[a_slot] <= 1'b0;
            end
            if (meta_dirty)
            begin
                dirty_reg[a_slot] <= 1'b1;
            end
            priority if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        pend_off_reg <= cnt_off;
        hit_reg      <= hit_next;
        if (req.valid && req.ready)
        begin
            op_reg    <= req.operation;
            addr_reg  <= MEM_ADDR_W'(req.address);
            wdata_reg <= req.write_data;
        end
        if (meta_fill)
        begin
            tag_reg[a_slot] <= a_tag;
        end
        if (rsp_load)
        begin
            rsp_hit_reg  <= hit_reg;
            rsp_data_reg <= (op_reg == dmwbc_pkg::OP_WRITE) ? '0 : line_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (line_we)
        begin
            line_mem[line_waddr] <= line_wdata;
        end
        if (line_re)
        begin
            line_q <= line_mem[line_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_we)
        begin
            back_mem[back_waddr] <= back_wdata;
        end
        if (back_re)
        begin
            back_q <= back_mem[back_raddr];
        end
    end

endmodule
